/* sv/multi_task_heartbeat_supervisor_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the heartbeat supervisor RTL
// ----------------------------------------------------------------------------
`ifndef MULTI_TASK_HEARTBEAT_SUPERVISOR_ASSERT_SVH
`define MULTI_TASK_HEARTBEAT_SUPERVISOR_ASSERT_SVH

// same-cycle implication, reset masked
`define MTHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define MTHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mths_pkg.sv */
// ----------------------------------------------------------------------------
// mths_pkg
// Types and constants of the heartbeat supervisor.
// ----------------------------------------------------------------------------
package mths_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHID_W     = 5;
    localparam int CH_LIMIT_W = CHID_W + 1;
    localparam int TIME_W     = 32;
    localparam int TAG_W      = 8;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_KICK   = 2'd2,
        REQ_CHECK  = 2'd3
    } req_kind_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic              we;
        logic              owner_we;
        logic [CH_W-1:0]   addr;
        logic [TIME_W-1:0] stamp;
        logic [TAG_W-1:0]  owner;
    } store_wr_t;

endpackage

/* sv/mths_store.sv */
// ----------------------------------------------------------------------------
// mths_store
// Per-channel timestamp and owner tag registers, one write port, one read.
// ----------------------------------------------------------------------------
module mths_store
    import mths_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_wr_t         wr,
    input  logic [CH_W-1:0]   rd_idx,
    output logic [TIME_W-1:0] rd_stamp,
    output logic [TAG_W-1:0]  rd_owner
);

    logic [TIME_W-1:0] stamp_reg [CHANNELS];
    logic [TAG_W-1:0]  owner_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                stamp_reg[i] <= '0;
                owner_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.we)
            begin
                stamp_reg[wr.addr] <= wr.stamp;
            end
            if (wr.owner_we)
            begin
                owner_reg[wr.addr] <= wr.owner;
            end
        end
    end

    assign rd_stamp = stamp_reg[rd_idx];
    assign rd_owner = owner_reg[rd_idx];

endmodule

/* sv/mths_cmp_unit.sv */
// ----------------------------------------------------------------------------
// mths_cmp_unit
// Shared evaluation of one channel: staleness and owner tag match.
// ----------------------------------------------------------------------------
module mths_cmp_unit
    import mths_pkg::*;
(
    input  logic [TIME_W-1:0] time_now,
    input  logic [TIME_W-1:0] timeout,
    input  logic [TIME_W-1:0] stamp,
    input  logic [TAG_W-1:0]  owner,
    input  logic [TAG_W-1:0]  tag,
    output logic              stale,
    output logic              hit
);

    logic [TIME_W-1:0] age;

    // wrapping age; a zero stamp means never reported
    assign age   = time_now - stamp;
    assign stale = (stamp != '0) && (age > timeout);
    assign hit   = (tag != '0) && (owner == tag);

endmodule

/* sv/mths_seq.sv */
// ----------------------------------------------------------------------------
// mths_seq
// Request sequencer: decodes a command word, scans channels one per cycle
// through the shared compare unit, and registers the result word.
// ----------------------------------------------------------------------------
module mths_seq
    import mths_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    input  logic [CHID_W-1:0] channel_id,
    input  logic [TAG_W-1:0]  owner_tag,
    input  logic [TIME_W-1:0] time_now,
    input  logic              stale,
    input  logic              hit,
    output logic [CH_W-1:0]   scan_idx,
    output logic [TAG_W-1:0]  scan_tag,
    output store_wr_t         wr,
    output logic              busy,
    output logic              done,
    output logic              feed_watchdog,
    output logic              any_dead,
    output logic [CHID_W-1:0] dead_channel,
    output logic              kick_matched
);

    state_t            state_reg, state_next;
    req_kind_t         kind_reg, kind_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [CH_W-1:0]   idx_reg, idx_next;
    logic              done_reg, done_next;
    logic              feed_reg, feed_next;
    logic              dead_reg, dead_next;
    logic [CHID_W-1:0] dead_ch_reg, dead_ch_next;
    logic              match_reg, match_next;
    req_kind_t         kind_in;
    logic              last_ch;

    assign kind_in = req_kind_t'(req_type);
    assign last_ch = (idx_reg == CH_W'(CHANNELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        tag_reg     <= tag_next;
        idx_reg     <= idx_next;
        feed_reg    <= feed_next;
        dead_reg    <= dead_next;
        dead_ch_reg <= dead_ch_next;
        match_reg   <= match_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        tag_next     = tag_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        feed_next    = feed_reg;
        dead_next    = dead_reg;
        dead_ch_next = dead_ch_reg;
        match_next   = match_reg;
        wr           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind_in;
                    tag_next  = owner_tag;
                    idx_next  = '0;
                    unique case (kind_in)
                        REQ_TICK:
                        begin
                            done_next    = 1'b1;
                            feed_next    = 1'b0;
                            dead_next    = 1'b0;
                            dead_ch_next = '0;
                            match_next   = 1'b0;
                        end
                        REQ_UPDATE:
                        begin
                            if (CH_LIMIT_W'(channel_id) < CH_LIMIT_W'(CHANNELS))
                            begin
                                wr.we       = 1'b1;
                                wr.owner_we = 1'b1;
                                wr.addr     = channel_id[CH_W-1:0];
                                wr.stamp    = time_now;
                                wr.owner    = owner_tag;
                            end
                            done_next    = 1'b1;
                            feed_next    = 1'b0;
                            dead_next    = 1'b0;
                            dead_ch_next = '0;
                            match_next   = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (kind_reg == REQ_KICK)
                begin
                    if (hit)
                    begin
                        // restamp first channel owned by this tag
                        wr.we        = 1'b1;
                        wr.addr      = idx_reg;
                        wr.stamp     = time_now;
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        feed_next    = 1'b0;
                        dead_next    = 1'b0;
                        dead_ch_next = '0;
                        match_next   = 1'b1;
                    end
                    else if (last_ch)
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        feed_next    = 1'b0;
                        dead_next    = 1'b0;
                        dead_ch_next = '0;
                        match_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (stale)
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        feed_next    = 1'b0;
                        dead_next    = 1'b1;
                        dead_ch_next = CHID_W'(idx_reg);
                        match_next   = 1'b0;
                    end
                    else if (last_ch)
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        feed_next    = 1'b1;
                        dead_next    = 1'b0;
                        dead_ch_next = '0;
                        match_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign scan_idx      = idx_reg;
    assign scan_tag      = tag_reg;
    assign busy          = (state_reg == S_SCAN);
    assign done          = done_reg;
    assign feed_watchdog = feed_reg;
    assign any_dead      = dead_reg;
    assign dead_channel  = dead_ch_reg;
    assign kick_matched  = match_reg;

`include "multi_task_heartbeat_supervisor_assert.svh"

    `MTHS_ASSERT_NOW(a_feed_dead_excl, done_reg, !(feed_reg && dead_reg), "feed with dead channel")
    `MTHS_ASSERT_NOW(a_match_alone, done_reg && match_reg, !feed_reg && !dead_reg, "kick word has check flags")
    `MTHS_ASSERT_NEXT(a_scan_starts, start && !busy && (req_type == REQ_KICK || req_type == REQ_CHECK), busy && !done, "scan did not start")
    `MTHS_ASSERT_NEXT(a_stale_reported, state_reg == S_SCAN && kind_reg == REQ_CHECK && stale, done && dead_reg && !busy, "stale channel not reported")
    `MTHS_ASSERT_NEXT(a_short_done, start && !busy && (req_type == REQ_TICK || req_type == REQ_UPDATE), done && !busy, "no word after tick or update")

endmodule

/* sv/multi_task_heartbeat_supervisor.sv */
// ----------------------------------------------------------------------------
// multi_task_heartbeat_supervisor
// Tick and update give their result word in the cycle after start, one word per cycle.
// Kick and check scan one channel per cycle through one shared compare unit:
// result word when the scan ends on a hit (kick), a stale channel (check) or the last channel;
// busy meanwhile, so no new word is taken while the scan runs.
// Result word is a one-cycle done strobe; the receiver cannot stall.
// Reset clears time, stamps, owner tags, and loads a 10000-tick timeout.
// ----------------------------------------------------------------------------
module multi_task_heartbeat_supervisor
    import mths_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        req_type,
    input  logic [CHID_W-1:0] channel_id,
    input  logic [TAG_W-1:0]  owner_tag,
    input  logic              cfg_we,
    input  logic [TIME_W-1:0] cfg_wdata,
    output logic              done,
    output logic              feed_watchdog,
    output logic              any_dead,
    output logic [CHID_W-1:0] dead_channel,
    output logic              kick_matched
);

    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic              tick;
    store_wr_t         wr;
    logic [CH_W-1:0]   scan_idx;
    logic [TAG_W-1:0]  scan_tag;
    logic [TIME_W-1:0] rd_stamp;
    logic [TAG_W-1:0]  rd_owner;
    logic              stale;
    logic              hit;

    assign tick = start && !busy && (req_kind_t'(req_type) == REQ_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (tick)
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    mths_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_idx   (scan_idx),
        .rd_stamp (rd_stamp),
        .rd_owner (rd_owner)
    );

    mths_cmp_unit u_cmp (
        .time_now (time_reg),
        .timeout  (timeout_reg),
        .stamp    (rd_stamp),
        .owner    (rd_owner),
        .tag      (scan_tag),
        .stale    (stale),
        .hit      (hit)
    );

    mths_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_type      (req_type),
        .channel_id    (channel_id),
        .owner_tag     (owner_tag),
        .time_now      (time_reg),
        .stale         (stale),
        .hit           (hit),
        .scan_idx      (scan_idx),
        .scan_tag      (scan_tag),
        .wr            (wr),
        .busy          (busy),
        .done          (done),
        .feed_watchdog (feed_watchdog),
        .any_dead      (any_dead),
        .dead_channel  (dead_channel),
        .kick_matched  (kick_matched)
    );

endmodule
